@@ rtl/core/gcol_pkg.sv @@
// Shared constants and control types for the greedy graph colouring unit.
// No dependencies; compile before every other file of the block.
`default_nettype none

package gcol_pkg;

  localparam int MaxVerticesDef = 64;   // default capacity of the colour store
  localparam int MaskW          = 64;   // adjacency bits per vertex
  localparam int ColourW        = 6;    // colour and vertex index width
  localparam int CountW         = 7;    // vertex and colour counters

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // transfer in an item, apply the start flag
    logic scan_rd;   // read one stored colour, advance the scan
    logic commit;    // write the result register and update the map
  } gcol_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;       // map holds its capacity of vertices
    logic scan_done;  // every earlier vertex has been read
    logic out_free;   // result register can take a new result
  } gcol_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/gcol_if.sv @@
// Valid/ready channel interfaces for the colouring unit's item and result streams.
// Depends on gcol_pkg for field widths.
`default_nettype none

interface gcol_in_if;
  logic                         valid;
  logic                         ready;
  logic                         start_new_map;
  logic [gcol_pkg::MaskW-1:0]   neighbour_mask;

  modport source (output valid, output start_new_map, output neighbour_mask, input ready);
  modport sink   (input valid, input start_new_map, input neighbour_mask, output ready);
endinterface

interface gcol_out_if;
  logic                         valid;
  logic                         ready;
  logic [gcol_pkg::ColourW-1:0] vertex_index;
  logic [gcol_pkg::ColourW-1:0] colour;
  logic [gcol_pkg::CountW-1:0]  colours_in_use;
  logic                         overflow;

  modport source (output valid, output vertex_index, output colour,
                  output colours_in_use, output overflow, input ready);
  modport sink   (input valid, input vertex_index, input colour,
                  input colours_in_use, input overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gcol_ctrl.sv @@
// Controller for the colouring unit: sequences load, colour-store scan and commit.
// Depends on gcol_pkg for the command and status structs.
`default_nettype none

module gcol_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gcol_pkg::gcol_sts_t sts,
  output gcol_pkg::gcol_cmd_t      cmd
);
  import gcol_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.scan_rd = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // a full map skips the scan and reports overflow
        if (sts.full || sts.scan_done) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gcol_dp.sv @@
// Datapath for the colouring unit: colour store, used-colour set, counters and
// result register. Depends on gcol_pkg and gcol_if.
`default_nettype none

module gcol_dp #(
  parameter int MAX_VERTICES = gcol_pkg::MaxVerticesDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_start_new_map,
  input  wire logic [gcol_pkg::MaskW-1:0] in_neighbour_mask,
  input  wire gcol_pkg::gcol_cmd_t        cmd,
  output gcol_pkg::gcol_sts_t             sts,
  gcol_out_if.source                      out_ch
);
  import gcol_pkg::*;

  localparam int AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [CountW-1:0] Cap = CountW'(MAX_VERTICES);

  logic [ColourW-1:0] colour_mem [MAX_VERTICES];

  logic [MaskW-1:0]   mask_r;
  logic [MaskW-1:0]   used_r;
  logic [CountW-1:0]  vertex_count_r;
  logic [CountW-1:0]  colour_count_r;
  logic [CountW-1:0]  scan_cnt_r;
  logic               rd_valid_r;
  logic [ColourW-1:0] rd_idx_r;
  logic [ColourW-1:0] rd_data_r;

  logic               out_valid_r;
  logic [ColourW-1:0] out_vertex_index_r;
  logic [ColourW-1:0] out_colour_r;
  logic [CountW-1:0]  out_colours_in_use_r;
  logic               out_overflow_r;

  logic [ColourW-1:0] free_colour;
  logic               opens_new;

  assign sts.full      = (vertex_count_r >= Cap);
  assign sts.scan_done = (scan_cnt_r == vertex_count_r);
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  // Lowest clear bit of the used set; colours at or above colour_count are
  // never marked, so a clear bit always exists below capacity.
  always_comb begin
    free_colour = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_colour = ColourW'(i);
      end
    end
  end

  assign opens_new = ({1'b0, free_colour} == colour_count_r);

  // Colour store: one write at each commit that does not overflow, one registered read per scan step
  always_ff @(posedge clk) begin
    if (cmd.commit && !sts.full) begin
      colour_mem[vertex_count_r[AddrW-1:0]] <= free_colour;
    end
    rd_data_r <= colour_mem[scan_cnt_r[AddrW-1:0]];
    rd_idx_r  <= ColourW'(scan_cnt_r[AddrW-1:0]);
  end

  // Payload: mask and used set
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask_r <= in_neighbour_mask;
      used_r <= '0;
    end else if (rd_valid_r && mask_r[rd_idx_r]) begin
      used_r[rd_data_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= '0;
      colour_count_r <= '0;
      scan_cnt_r     <= '0;
      rd_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      rd_valid_r <= cmd.scan_rd;
      if (cmd.load) begin
        scan_cnt_r <= '0;
        if (in_start_new_map) begin
          vertex_count_r <= '0;
          colour_count_r <= '0;
        end
      end else if (cmd.scan_rd) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (!sts.full) begin
          vertex_count_r <= vertex_count_r + 1'b1;
          if (opens_new) begin
            colour_count_r <= colour_count_r + 1'b1;
          end
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: hold until the next commit
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (sts.full) begin
        out_vertex_index_r   <= '0;
        out_colour_r         <= '0;
        out_colours_in_use_r <= colour_count_r;
        out_overflow_r       <= 1'b1;
      end else begin
        out_vertex_index_r   <= vertex_count_r[ColourW-1:0];
        out_colour_r         <= free_colour;
        out_colours_in_use_r <= opens_new ? colour_count_r + 1'b1 : colour_count_r;
        out_overflow_r       <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.vertex_index   = out_vertex_index_r;
  assign out_ch.colour         = out_colour_r;
  assign out_ch.colours_in_use = out_colours_in_use_r;
  assign out_ch.overflow       = out_overflow_r;

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ch.ready))
    else $error("commit while result register occupied");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("committed result not presented");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    colour_count_r <= vertex_count_r)
    else $error("more colours than vertices");

  a_colour_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.overflow) |-> ({1'b0, out_ch.colour} < out_ch.colours_in_use))
    else $error("colour not below colours in use");

endmodule

`default_nettype wire

@@ rtl/core/greedy_graph_colouring_unit.sv @@
// First-fit greedy vertex colouring, top level. Depends on gcol_pkg, gcol_if,
// gcol_ctrl and gcol_dp.
// Each item scans the colour store, one earlier vertex per cycle (overflow items skip
// the scan), then commits its result once the result register is free.
// A new item is taken only after the previous one has been committed.
// Reset (rst_n low, synchronous) empties the map; the colour store needs no clearing.
`default_nettype none

module greedy_graph_colouring_unit #(
  parameter int MAX_VERTICES = gcol_pkg::MaxVerticesDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  gcol_in_if.sink   in_ch,
  gcol_out_if.source out_ch
);
  import gcol_pkg::*;

  gcol_cmd_t cmd;
  gcol_sts_t sts;

  gcol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gcol_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_start_new_map  (in_ch.start_new_map),
    .in_neighbour_mask (in_ch.neighbour_mask),
    .cmd               (cmd),
    .sts               (sts),
    .out_ch            (out_ch)
  );

endmodule

`default_nettype wire
